/* rtl/sno_pkg.sv */
// Shared types, constants and the square-root step for the Sobel edge-thinning core.
package sno_pkg;

  localparam int GRAY_W     = 8;
  localparam int MAG_W      = 11;
  localparam int DIR_W      = 2;
  localparam int GRAD_W     = 11;
  localparam int SUM_W      = 22;
  localparam int CFG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int SQ_STAGES  = 3;
  localparam int SQ_PER     = 4;
  localparam int SQ_STEPS   = SQ_STAGES * SQ_PER;
  localparam int SQ_IN_W    = 2 * SQ_STEPS;
  localparam int ROOT_W     = SQ_STEPS;
  localparam int REM_W      = ROOT_W + 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [DIR_W-1:0] DIR_HORZ = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DIAG = 2'd1;
  localparam logic [DIR_W-1:0] DIR_ANTI = 2'd2;
  localparam logic [DIR_W-1:0] DIR_VERT = 2'd3;

  localparam logic [21:0] TAN22 = 22'd423652;
  localparam logic [21:0] TAN23 = 22'd445094;
  localparam logic [21:0] TAN67 = 22'd2470290;
  localparam logic [21:0] TAN68 = 22'd2595317;

  typedef struct packed {
    logic out_ok;
    logic inner;
    logic last;
  } pos_flags_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] q;
  } sqrt_acc_t;

  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t a, logic [1:0] bits);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] t;
    sqrt_acc_t r;
    cur = {a.rem, bits};
    t = {{(REM_W - ROOT_W){1'b0}}, a.q, 2'b01};
    if (cur >= t) begin
      r.rem = REM_W'(cur - t);
      r.q = {a.q[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem = REM_W'(cur);
      r.q = {a.q[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/sno_grad.sv */
// Frame counters, gray line store, 3x3 window, Sobel gradient, sum of squares and direction.
module sno_grad import sno_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  in_valid,
  input  logic [GRAY_W-1:0]     gray,
  input  logic                  pad,
  input  logic                  adv,
  output logic                  s_valid,
  output logic [SUM_W-1:0]      s_sum,
  output logic [DIR_W-1:0]      s_dir,
  output pos_flags_t            s_flags,
  output logic [$clog2(MAX_WIDTH)-1:0] s_cm
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = ((WW > 11) ? WW : 11) + 1;

  logic [10:0] width_reg;
  logic [11:0] height_reg;
  logic [CW-1:0] col;
  logic [12:0] row;

  logic [XW-1:0] wx, wcl;
  logic [WW-1:0] wcn, col_inc;
  logic [11:0] hc;
  logic signed [13:0] rs, rq, hcs;
  logic [WW:0] cq, wce;
  logic col_ge2, cen, take;
  pos_flags_t flg;
  logic [CW-1:0] cm;

  always_comb begin
    wx = XW'(width_reg);
    if (wx < XW'(3)) wcl = XW'(3);
    else if (wx > XW'(MAX_WIDTH)) wcl = XW'(MAX_WIDTH);
    else wcl = wx;
    wcn = WW'(wcl);
    wce = (WW+1)'(wcn);
    hc = (height_reg < 12'd3) ? 12'd3 : height_reg;
    hcs = $signed({2'b00, hc});
    col_ge2 = col >= CW'(2);
    cen = col_ge2 && (row >= 13'd2) && (row <= {1'b0, hc} - 13'd1);
    rs = $signed({1'b0, row});
    rq = col_ge2 ? rs - 14'sd2 : rs - 14'sd3;
    cq = col_ge2 ? (WW+1)'(col) - (WW+1)'(2) : (WW+1)'(col) + wce - (WW+1)'(2);
    flg.out_ok = (rq >= 14'sd0) && (rq < hcs);
    flg.inner = (rq >= 14'sd1) && (rq <= hcs - 14'sd2) &&
                (cq >= (WW+1)'(1)) && (cq <= wce - (WW+1)'(2));
    flg.last = (rq == hcs - 14'sd1) && (cq == wce - (WW+1)'(1));
    cm = (col != '0) ? col - CW'(1) : CW'(wcn - WW'(1));
    col_inc = WW'(col) + WW'(1);
    take = in_valid && adv && !(pad && row == '0 && col == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= 11'd640;
      height_reg <= 12'd480;
      col <= '0;
      row <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_WIDTH: begin
          width_reg <= cfg_data[10:0];
          col <= '0;
          row <= '0;
        end
        CFG_HEIGHT: begin
          height_reg <= cfg_data;
          col <= '0;
          row <= '0;
        end
        default: ;
      endcase
    end else if (take) begin
      if (flg.last) begin
        col <= '0;
        row <= '0;
      end else if (col_inc >= wcn) begin
        col <= '0;
        row <= row + 13'd1;
      end else begin
        col <= CW'(col_inc);
      end
    end
  end

  // stage 0: item plus line store read
  logic v0, cen0;
  logic [GRAY_W-1:0] g0;
  logic [CW-1:0] c0, cm0;
  pos_flags_t f0;
  logic [2*GRAY_W-1:0] grd;
  logic [2*GRAY_W-1:0] gmem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (adv) grd <= gmem[col];
    if (adv && v0) gmem[c0] <= {grd[GRAY_W-1:0], g0};
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= take;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g0 <= pad ? '0 : gray;
      c0 <= col;
      cm0 <= cm;
      cen0 <= cen;
      f0 <= flg;
    end
  end

  // stage 1: window and gradient
  logic [GRAY_W-1:0] win [9];
  logic [GRAY_W-1:0] win_next [9];
  logic [11:0] gxw, gyw;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k*3] = win[k*3+1];
      win_next[k*3+1] = win[k*3+2];
    end
    win_next[2] = grd[2*GRAY_W-1:GRAY_W];
    win_next[5] = grd[GRAY_W-1:0];
    win_next[8] = g0;
    gxw = {4'b0, win_next[0]} + {3'b0, win_next[3], 1'b0} + {4'b0, win_next[6]}
        - {4'b0, win_next[2]} - {3'b0, win_next[5], 1'b0} - {4'b0, win_next[8]};
    gyw = {4'b0, win_next[0]} + {3'b0, win_next[1], 1'b0} + {4'b0, win_next[2]}
        - {4'b0, win_next[6]} - {3'b0, win_next[7], 1'b0} - {4'b0, win_next[8]};
  end

  always_ff @(posedge clk) begin
    if (adv && v0) win <= win_next;
  end

  logic v1;
  logic [GRAD_W-1:0] gx1, gy1;
  logic [CW-1:0] cm1;
  pos_flags_t f1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx1 <= cen0 ? gxw[GRAD_W-1:0] : '0;
      gy1 <= cen0 ? gyw[GRAD_W-1:0] : '0;
      cm1 <= cm0;
      f1 <= f0;
    end
  end

  // stage 2: squares and direction class
  logic [GRAD_W-1:0] ax, ay;
  logic [SUM_W-1:0] sqx, sqy;
  logic [32:0] ys, pa, pb;
  logic gx_neg, gy_neg, same, lt_a, lt_b;
  logic [DIR_W-1:0] dir;

  always_comb begin
    gx_neg = gx1[GRAD_W-1];
    gy_neg = gy1[GRAD_W-1];
    ax = gx_neg ? GRAD_W'(-gx1) : gx1;
    ay = gy_neg ? GRAD_W'(-gy1) : gy1;
    sqx = SUM_W'(ax) * SUM_W'(ax);
    sqy = SUM_W'(ay) * SUM_W'(ay);
    ys = {2'b0, ay, 20'b0};
    pa = 33'(gx_neg ? TAN22 : TAN23) * 33'(ax);
    pb = 33'(gx_neg ? TAN67 : TAN68) * 33'(ax);
    lt_a = gx_neg ? (ys <= pa) : (ys < pa);
    lt_b = gx_neg ? (ys <= pb) : (ys < pb);
    same = (gx1 != '0 && gy1 != '0) && (gx_neg == gy_neg);
    if (gx1 == '0 && gy1 == '0) dir = DIR_HORZ;
    else if (lt_a) dir = DIR_HORZ;
    else if (lt_b) dir = same ? DIR_DIAG : DIR_ANTI;
    else dir = DIR_VERT;
  end

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (adv) s_valid <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_sum <= sqx + sqy;
      s_dir <= dir;
      s_flags <= f1;
      s_cm <= cm1;
    end
  end

endmodule

/* rtl/sno_isqrt.sv */
// Pipelined integer square root, four result bits per stage.
module sno_isqrt import sno_pkg::*; (
  input  logic             clk,
  input  logic             adv,
  input  logic [SUM_W-1:0] in_sum,
  output logic [MAG_W-1:0] root
);

  sqrt_acc_t acc_r [SQ_STAGES];
  logic [SQ_IN_W-1:0] s_r [SQ_STAGES];

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [SQ_IN_W-1:0] src;
    sqrt_acc_t start;
    sqrt_acc_t nxt;
    if (k == 0) begin : g_first
      assign src = SQ_IN_W'(in_sum);
      assign start = '0;
    end else begin : g_rest
      assign src = s_r[k-1];
      assign start = acc_r[k-1];
    end
    always_comb begin
      nxt = start;
      for (int j = 0; j < SQ_PER; j++) begin
        nxt = sqrt_step(nxt, src[2*(SQ_STEPS-1-k*SQ_PER-j) +: 2]);
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        s_r[k] <= src;
        acc_r[k] <= nxt;
      end
    end
  end

  assign root = acc_r[SQ_STAGES-1].q[MAG_W-1:0];

endmodule

/* rtl/sno_nms.sv */
// Magnitude line store, 3x3 magnitude window, non-maximum suppression and output register.
module sno_nms import sno_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [MAG_W-1:0]     in_mag,
  input  logic [DIR_W-1:0]     in_dir,
  input  pos_flags_t           in_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_cm,
  input  logic                 out_ready,
  output logic                 adv,
  output logic                 out_valid,
  output logic                 edge_bit,
  output logic [MAG_W-1:0]     magnitude,
  output logic [DIR_W-1:0]     direction,
  output logic                 last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic v6;
  logic [MAG_W-1:0] mag6;
  logic [DIR_W-1:0] dir6, drd, hold;
  pos_flags_t f6;
  logic [CW-1:0] cm6;
  logic [2*MAG_W-1:0] mrd;
  logic [2*MAG_W-1:0] mmem [MAX_WIDTH];
  logic [DIR_W-1:0] dmem [MAX_WIDTH];
  logic [MAG_W-1:0] mwin [9];
  logic [MAG_W-1:0] mwin_next [9];
  logic [MAG_W-1:0] n1, n2;
  logic ge;

  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (adv) begin
      mrd <= mmem[in_cm];
      drd <= dmem[in_cm];
    end
    if (adv && v6) begin
      mmem[cm6] <= {mrd[MAG_W-1:0], mag6};
      dmem[cm6] <= dir6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag6 <= in_mag;
      dir6 <= in_dir;
      f6 <= in_flags;
      cm6 <= in_cm;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mwin_next[k*3] = mwin[k*3+1];
      mwin_next[k*3+1] = mwin[k*3+2];
    end
    mwin_next[2] = mrd[2*MAG_W-1:MAG_W];
    mwin_next[5] = mrd[MAG_W-1:0];
    mwin_next[8] = mag6;
    case (hold)
      DIR_HORZ: begin n1 = mwin_next[3]; n2 = mwin_next[5]; end
      DIR_DIAG: begin n1 = mwin_next[2]; n2 = mwin_next[6]; end
      DIR_ANTI: begin n1 = mwin_next[0]; n2 = mwin_next[8]; end
      default:  begin n1 = mwin_next[1]; n2 = mwin_next[7]; end
    endcase
    ge = (mwin_next[4] >= n1) && (mwin_next[4] >= n2);
  end

  always_ff @(posedge clk) begin
    if (adv && v6) begin
      mwin <= mwin_next;
      hold <= drd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= v6 && f6.out_ok;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_bit <= f6.inner && ge;
      magnitude <= f6.inner ? mwin_next[4] : '0;
      direction <= f6.inner ? hold : DIR_HORZ;
      last <= f6.last;
    end
  end

endmodule

/* rtl/sobel_nonmax_suppression_core.sv */
// Top level of the streaming Sobel gradient and non-maximum suppression core.
// Pixels enter in raster order at one per clock; a result leaves after the item that
// completes it, which is 2*W+2 items after the pixel itself, so each frame is followed
// by 2*W+2 pad items to flush it. The rate is one item per cycle, set by the simple
// dual-port line stores for gray, magnitude and direction (one read and one write each
// per cycle) and the three-stage square-root pipeline. The whole pipeline holds when
// the output register is full and not taken. Border pixels report zero.
module sobel_nonmax_suppression_core import sno_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [GRAY_W-1:0]    gray,
  input  logic                 pad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 edge_bit,
  output logic [MAG_W-1:0]     magnitude,
  output logic [DIR_W-1:0]     direction,
  output logic                 last
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic adv;
  logic s_valid;
  logic [SUM_W-1:0] s_sum;
  logic [DIR_W-1:0] s_dir;
  pos_flags_t s_flags;
  logic [CW-1:0] s_cm;
  logic [MAG_W-1:0] root;

  logic d_valid [SQ_STAGES];
  logic [DIR_W-1:0] d_dir [SQ_STAGES];
  pos_flags_t d_flags [SQ_STAGES];
  logic [CW-1:0] d_cm [SQ_STAGES];

  assign in_ready = adv;

  sno_grad #(.MAX_WIDTH(MAX_WIDTH)) u_grad (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .gray(gray), .pad(pad), .adv(adv),
    .s_valid(s_valid), .s_sum(s_sum), .s_dir(s_dir), .s_flags(s_flags), .s_cm(s_cm)
  );

  sno_isqrt u_isqrt (.clk(clk), .adv(adv), .in_sum(s_sum), .root(root));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_STAGES; k++) d_valid[k] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= s_valid;
      for (int k = 1; k < SQ_STAGES; k++) d_valid[k] <= d_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_dir[0] <= s_dir;
      d_flags[0] <= s_flags;
      d_cm[0] <= s_cm;
      for (int k = 1; k < SQ_STAGES; k++) begin
        d_dir[k] <= d_dir[k-1];
        d_flags[k] <= d_flags[k-1];
        d_cm[k] <= d_cm[k-1];
      end
    end
  end

  sno_nms #(.MAX_WIDTH(MAX_WIDTH)) u_nms (
    .clk(clk), .rst(rst),
    .in_valid(d_valid[SQ_STAGES-1]), .in_mag(root), .in_dir(d_dir[SQ_STAGES-1]),
    .in_flags(d_flags[SQ_STAGES-1]), .in_cm(d_cm[SQ_STAGES-1]),
    .out_ready(out_ready), .adv(adv),
    .out_valid(out_valid), .edge_bit(edge_bit), .magnitude(magnitude),
    .direction(direction), .last(last)
  );

  a_last_border: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !edge_bit && magnitude == '0 && direction == DIR_HORZ)
    else $error("last pixel of frame not reported as border");

  a_zero_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && magnitude == '0 |-> direction == DIR_HORZ)
    else $error("zero magnitude with non-horizontal direction");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= MAG_W'(1442))
    else $error("magnitude out of range");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(d_valid[SQ_STAGES-1]) && $stable(root))
    else $error("pipeline moved during stall");

endmodule
